// File: hw/rtl/tirf_pkg.sv
// Shared types, telnet protocol constants and the negotiation burst table.
package tirf_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  kind_t;
  typedef logic [23:0] tick_t;
  typedef logic [3:0]  burst_idx_t;

  // Input item kinds
  localparam kind_t KIND_BYTE  = 2'd0;
  localparam kind_t KIND_TICK  = 2'd1;
  localparam kind_t KIND_START = 2'd2;
  localparam kind_t KIND_RESET = 2'd3;

  // Telnet command bytes
  localparam byte_t TN_IAC  = 8'd255;
  localparam byte_t TN_DONT = 8'd254;
  localparam byte_t TN_DO   = 8'd253;
  localparam byte_t TN_WONT = 8'd252;
  localparam byte_t TN_WILL = 8'd251;
  localparam byte_t TN_SB   = 8'd250;
  localparam byte_t TN_SE   = 8'd240;

  // Telnet options
  localparam byte_t OPT_BINARY = 8'd0;
  localparam byte_t OPT_ECHO   = 8'd1;
  localparam byte_t OPT_SGA    = 8'd3;

  localparam tick_t      TIMEOUT_RESET = 24'd1000;
  localparam burst_idx_t BURST_LAST    = 4'd11;

  // Session-start burst: WILL ECHO, WILL SGA, DO BINARY, WILL BINARY
  function automatic byte_t burst_byte(input burst_idx_t idx);
    byte_t b;
    begin
      case (idx)
        4'd0:    b = TN_IAC;
        4'd1:    b = TN_WILL;
        4'd2:    b = OPT_ECHO;
        4'd3:    b = TN_IAC;
        4'd4:    b = TN_WILL;
        4'd5:    b = OPT_SGA;
        4'd6:    b = TN_IAC;
        4'd7:    b = TN_DO;
        4'd8:    b = OPT_BINARY;
        4'd9:    b = TN_IAC;
        4'd10:   b = TN_WILL;
        4'd11:   b = OPT_BINARY;
        default: b = 8'd0;
      endcase
      return b;
    end
  endfunction

endpackage

// File: hw/rtl/tirf_ifs.sv
// Channel interfaces: input items, result items and the timeout write port.
interface tirf_item_if;
  import tirf_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  byte_t rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface tirf_result_if;
  import tirf_pkg::*;
  logic  valid;
  logic  ready;
  logic  uart_valid;
  byte_t uart_byte;
  logic  net_valid;
  byte_t net_byte;
  logic  last;
  logic  binary_mode;
  logic  timed_out;

  modport source (output valid, output uart_valid, output uart_byte, output net_valid,
                  output net_byte, output last, output binary_mode, output timed_out,
                  input ready);
  modport sink (input valid, input uart_valid, input uart_byte, input net_valid,
                input net_byte, input last, input binary_mode, input timed_out,
                output ready);
endinterface

interface tirf_cfg_if;
  import tirf_pkg::*;
  logic  valid;
  logic  ready;
  tick_t timeout_ticks;

  modport source (output valid, output timeout_ticks, input ready);
  modport sink (input valid, input timeout_ticks, output ready);
endinterface

// File: hw/rtl/telnet_iac_rx_filter_core.sv
// Telnet receive IAC filter with binary negotiation tracking and timeout.
// The result is registered: it appears in the cycle after its input transaction is accepted.
// Throughput: one byte, tick or reset item per cycle; a session start yields a burst of 12
//   negotiation bytes, the input staying blocked while the burst counter walks them.
//   A stalled result holds the input as well.
// Reset (rst, synchronous): parser in data state, flags and tick count cleared,
//   timeout limit set to 1000, no result pending.
module telnet_iac_rx_filter_core (
  input  logic clk,
  input  logic rst,
  tirf_item_if.sink     item,
  tirf_result_if.source result,
  tirf_cfg_if.sink      cfg
);
  import tirf_pkg::*;

  localparam logic [2:0] PS_DATA       = 3'd0;
  localparam logic [2:0] PS_IAC        = 3'd1;
  localparam logic [2:0] PS_OPTION     = 3'd2;
  localparam logic [2:0] PS_SUBNEG     = 3'd3;
  localparam logic [2:0] PS_SUBNEG_IAC = 3'd4;

  logic [2:0] parse_state, parse_state_next;
  byte_t      pending_command, pending_command_next;
  logic       peer_sends_binary, peer_sends_binary_next;
  logic       we_send_binary, we_send_binary_next;
  tick_t      elapsed_ticks, elapsed_ticks_next;
  tick_t      timeout_ticks;

  logic       burst_active;
  burst_idx_t burst_cnt;

  logic       out_free;
  logic       item_accept;
  logic       fwd;
  logic       binary_next;

  // Output stage is free when empty or being drained this cycle
  assign out_free    = !result.valid || result.ready;
  assign item.ready  = out_free && !burst_active;
  assign item_accept = item.valid && item.ready;
  assign cfg.ready   = 1'b1;

  // Hold the timeout limit
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      timeout_ticks <= cfg.timeout_ticks;
    end
  end

  // Parse one item and update session state
  always_comb begin
    parse_state_next       = parse_state;
    pending_command_next   = pending_command;
    peer_sends_binary_next = peer_sends_binary;
    we_send_binary_next    = we_send_binary;
    elapsed_ticks_next     = elapsed_ticks;
    fwd                    = 1'b0;
    case (item.kind)
      KIND_BYTE: begin
        case (parse_state)
          PS_IAC: begin
            if (item.rx_byte == TN_IAC) begin
              parse_state_next = PS_DATA;
              fwd              = 1'b1;
            end else if (item.rx_byte inside {TN_WILL, TN_WONT, TN_DO, TN_DONT}) begin
              pending_command_next = item.rx_byte;
              parse_state_next     = PS_OPTION;
            end else if (item.rx_byte == TN_SB) begin
              parse_state_next = PS_SUBNEG;
            end else begin
              parse_state_next = PS_DATA;
            end
          end
          PS_OPTION: begin
            if (item.rx_byte == OPT_BINARY) begin
              if (pending_command == TN_WILL) begin
                peer_sends_binary_next = 1'b1;
              end else if (pending_command == TN_DO) begin
                we_send_binary_next = 1'b1;
              end
            end
            parse_state_next = PS_DATA;
          end
          PS_SUBNEG: begin
            if (item.rx_byte == TN_IAC) begin
              parse_state_next = PS_SUBNEG_IAC;
            end
          end
          PS_SUBNEG_IAC: begin
            parse_state_next = (item.rx_byte == TN_SE) ? PS_DATA : PS_SUBNEG;
          end
          default: begin
            if (item.rx_byte == TN_IAC) begin
              parse_state_next = PS_IAC;
            end else begin
              parse_state_next = PS_DATA;
              fwd              = 1'b1;
            end
          end
        endcase
      end
      KIND_TICK: begin
        if (elapsed_ticks != '1) begin
          elapsed_ticks_next = elapsed_ticks + tick_t'(1);
        end
      end
      default: begin
        // Session start and connection reset both clear the session
        parse_state_next       = PS_DATA;
        pending_command_next   = 8'd0;
        peer_sends_binary_next = 1'b0;
        we_send_binary_next    = 1'b0;
        elapsed_ticks_next     = '0;
      end
    endcase
    binary_next = peer_sends_binary_next && we_send_binary_next;
  end

  // Commit session state on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state       <= PS_DATA;
      pending_command   <= 8'd0;
      peer_sends_binary <= 1'b0;
      we_send_binary    <= 1'b0;
      elapsed_ticks     <= '0;
    end else if (item_accept) begin
      parse_state       <= parse_state_next;
      pending_command   <= pending_command_next;
      peer_sends_binary <= peer_sends_binary_next;
      we_send_binary    <= we_send_binary_next;
      elapsed_ticks     <= elapsed_ticks_next;
    end
  end

  // Advance the burst counter through the negotiation bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_active <= 1'b0;
      burst_cnt    <= '0;
    end else if (item_accept && item.kind == KIND_START) begin
      burst_active <= 1'b1;
      burst_cnt    <= burst_idx_t'(1);
    end else if (burst_active && out_free) begin
      if (burst_cnt == BURST_LAST) begin
        burst_active <= 1'b0;
        burst_cnt    <= '0;
      end else begin
        burst_cnt <= burst_cnt + burst_idx_t'(1);
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= item_accept || burst_active;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (burst_active) begin
        result.uart_valid  <= 1'b0;
        result.uart_byte   <= 8'd0;
        result.net_valid   <= 1'b1;
        result.net_byte    <= burst_byte(burst_cnt);
        result.last        <= (burst_cnt == BURST_LAST);
        result.binary_mode <= 1'b0;
        result.timed_out   <= (timeout_ticks == '0);
      end else if (item.kind == KIND_START) begin
        result.uart_valid  <= 1'b0;
        result.uart_byte   <= 8'd0;
        result.net_valid   <= 1'b1;
        result.net_byte    <= burst_byte('0);
        result.last        <= 1'b0;
        result.binary_mode <= 1'b0;
        result.timed_out   <= (timeout_ticks == '0);
      end else begin
        result.uart_valid  <= fwd;
        result.uart_byte   <= fwd ? item.rx_byte : 8'd0;
        result.net_valid   <= 1'b0;
        result.net_byte    <= 8'd0;
        result.last        <= 1'b1;
        result.binary_mode <= binary_next;
        result.timed_out   <= !binary_next && (elapsed_ticks_next >= timeout_ticks);
      end
    end
  end

`ifndef SYNTH
  // No new transaction is taken while the burst runs
  a_burst_blocks_input: assert property (@(posedge clk) disable iff (rst)
    burst_active |-> !item.ready)
    else $error("input accepted during negotiation burst");

  // A running burst never sits on index zero
  a_burst_cnt_live: assert property (@(posedge clk) disable iff (rst)
    burst_active |-> (burst_cnt != '0))
    else $error("burst counter idle while burst active");

  // A session start launches the burst
  a_start_launches: assert property (@(posedge clk) disable iff (rst)
    (item_accept && item.kind == KIND_START) |=> burst_active)
    else $error("session start did not launch burst");

  // Data and negotiation bytes never share a result
  a_one_payload: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.uart_valid && result.net_valid))
    else $error("result carries both uart and net bytes");

  // Binary mode masks the timeout flag
  a_binary_no_timeout: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.binary_mode) |-> !result.timed_out)
    else $error("timeout flagged in binary mode");
`endif

endmodule

// File: test/telnet_iac_rx_filter_core_tb.sv
// Self-checking testbench for the telnet receive IAC filter core.
module telnet_iac_rx_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tirf_pkg::*;

  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    HOLDOFF_CYCLES = 300;
  localparam int    REPORT_MAX     = 10;
  localparam tick_t TICK_MAX       = '1;
  localparam byte_t TN_NOP         = 8'd241;
  localparam byte_t TN_GA          = 8'd249;

  // Negotiation burst sent on session start: WILL ECHO, WILL SGA, DO BINARY, WILL BINARY
  localparam logic [0:11][7:0] NEG_BURST = {
    TN_IAC, TN_WILL, OPT_ECHO, TN_IAC, TN_WILL, OPT_SGA,
    TN_IAC, TN_DO, OPT_BINARY, TN_IAC, TN_WILL, OPT_BINARY
  };

  typedef enum logic [2:0] {
    PS_DATA, PS_AFTER_IAC, PS_OPTION, PS_SUBNEG, PS_SUBNEG_IAC
  } parse_t;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN, OP_HOLDOFF} op_code_t;

  typedef struct packed {
    logic  uart_valid;
    byte_t uart_byte;
    logic  net_valid;
    byte_t net_byte;
    logic  last;
    logic  binary_mode;
    logic  timed_out;
  } rx_result_t;

  typedef struct {
    op_code_t code;
    kind_t    kind;
    byte_t    data;
    int       gap;
    tick_t    value;
  } stim_op_t;

  logic clk;
  logic rst;

  tirf_item_if   item_ch ();
  tirf_result_if result_ch ();
  tirf_cfg_if    cfg_ch ();

  telnet_iac_rx_filter_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Filter state mirrored by the testbench
  parse_t pstate;
  byte_t  pending_cmd;
  logic   peer_bin;
  logic   we_bin;
  tick_t  elapsed;
  tick_t  limit;

  rx_result_t exp_results[$];
  stim_op_t   op_queue[$];

  int  results_due;
  int  results_seen;
  int  errors;
  int  n_items;
  int  n_starts;
  int  n_resets;
  int  n_cfg;
  bit  stim_done;
  bit  tx_calm;
  logic holdoff_tog;

  function automatic void session_clear();
    pstate      = PS_DATA;
    pending_cmd = '0;
    peer_bin    = 1'b0;
    we_bin      = 1'b0;
    elapsed     = '0;
  endfunction

  // Advance the filter by one item and queue the results it produces
  function automatic int filter_step(kind_t k, byte_t b);
    rx_result_t r;
    logic       fwd;
    logic       bin;
    int         n;
    fwd = 1'b0;
    n   = 1;
    case (k)
      KIND_BYTE: begin
        case (pstate)
          PS_AFTER_IAC: begin
            if (b == TN_IAC) begin
              pstate = PS_DATA;
              fwd    = 1'b1;
            end else if (b >= TN_WILL && b <= TN_DONT) begin
              pending_cmd = b;
              pstate      = PS_OPTION;
            end else begin
              pstate = (b == TN_SB) ? PS_SUBNEG : PS_DATA;
            end
          end
          PS_OPTION: begin
            // WONT and DONT never clear a flag
            if (b == OPT_BINARY) begin
              if (pending_cmd == TN_WILL) peer_bin = 1'b1;
              else if (pending_cmd == TN_DO) we_bin = 1'b1;
            end
            pstate = PS_DATA;
          end
          PS_SUBNEG: begin
            if (b == TN_IAC) pstate = PS_SUBNEG_IAC;
          end
          PS_SUBNEG_IAC: begin
            pstate = (b == TN_SE) ? PS_DATA : PS_SUBNEG;
          end
          default: begin
            if (b == TN_IAC) begin
              pstate = PS_AFTER_IAC;
            end else begin
              pstate = PS_DATA;
              fwd    = 1'b1;
            end
          end
        endcase
      end
      KIND_TICK: begin
        if (elapsed != TICK_MAX) elapsed = elapsed + 1'b1;
      end
      KIND_START: begin
        session_clear();
        n = 12;
      end
      default: session_clear();
    endcase
    bin = peer_bin & we_bin;
    for (int i = 0; i < n; i++) begin
      r             = '0;
      r.binary_mode = bin;
      r.timed_out   = !bin && (elapsed >= limit);
      r.last        = (i == n - 1);
      if (k == KIND_START) begin
        r.net_valid = 1'b1;
        r.net_byte  = NEG_BURST[i];
      end else if (fwd) begin
        r.uart_valid = 1'b1;
        r.uart_byte  = b;
      end
      exp_results.push_back(r);
    end
    return n;
  endfunction

  // Stimulus queue helpers
  task automatic push_item(kind_t k, byte_t b);
    stim_op_t op;
    op.code  = OP_ITEM;
    op.kind  = k;
    op.data  = b;
    op.gap   = tx_calm ? 0 : $urandom_range(0, 16);
    op.value = '0;
    op_queue.push_back(op);
    n_items++;
  endtask

  task automatic push_ctrl(op_code_t c, tick_t v);
    stim_op_t op;
    op.code  = c;
    op.kind  = KIND_BYTE;
    op.data  = '0;
    op.gap   = 0;
    op.value = v;
    op_queue.push_back(op);
  endtask

  task automatic push_bytes(byte_t a, byte_t b, byte_t c, int n);
    push_item(KIND_BYTE, a);
    if (n > 1) push_item(KIND_BYTE, b);
    if (n > 2) push_item(KIND_BYTE, c);
  endtask

  // Mostly well-formed telnet traffic with random content, plus noise
  task automatic add_random_traffic(int target);
    int pick;
    int len;
    while (n_items < target) begin
      if ($urandom_range(0, 9) == 0) tx_calm = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        len = $urandom_range(1, 6);
        repeat (len) push_item(KIND_BYTE, byte_t'($urandom_range(0, 254)));
      end else if (pick < 38) begin
        push_bytes(TN_IAC, TN_IAC, 8'd0, 2);
      end else if (pick < 58) begin
        push_bytes(TN_IAC, byte_t'($urandom_range(TN_WILL, TN_DONT)),
                   ($urandom_range(0, 1) == 0) ? OPT_BINARY : byte_t'($urandom_range(0, 255)),
                   3);
      end else if (pick < 64) begin
        push_bytes(TN_IAC, byte_t'($urandom_range(TN_SE, TN_GA)), 8'd0, 2);
      end else if (pick < 72) begin
        push_bytes(TN_IAC, TN_SB, 8'd0, 2);
        len = $urandom_range(0, 5);
        repeat (len) push_item(KIND_BYTE, byte_t'($urandom_range(0, 255)));
        push_bytes(TN_IAC, TN_SE, 8'd0, 2);
      end else if (pick < 84) begin
        len = $urandom_range(1, 8);
        repeat (len) push_item(KIND_TICK, byte_t'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        push_item(KIND_START, byte_t'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        push_item(KIND_RESET, byte_t'($urandom_range(0, 255)));
      end else begin
        push_item(KIND_BYTE,
                  ($urandom_range(0, 1) == 0) ? TN_IAC : byte_t'($urandom_range(0, 255)));
      end
    end
  endtask

  // Driver: present items and register writes, record accepted transactions
  int       gap_cnt;
  int       settle;
  bit       draining;
  bit       hold;
  logic     nxt_item_valid;
  logic     nxt_cfg_valid;
  stim_op_t cur_op;

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      cfg_ch.valid  <= 1'b0;
      holdoff_tog   <= 1'b0;
      gap_cnt       = 0;
      settle        = 0;
      draining      = 1'b0;
      limit         = TIMEOUT_RESET;
      results_due   <= 0;
      session_clear();
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        if (item_ch.kind == KIND_START) n_starts++;
        if (item_ch.kind == KIND_RESET) n_resets++;
        results_due <= results_due + filter_step(item_ch.kind, item_ch.rx_byte);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        limit = cfg_ch.timeout_ticks;
        n_cfg++;
      end
      hold = (item_ch.valid && !item_ch.ready) || (cfg_ch.valid && !cfg_ch.ready);
      if (!hold) begin
        nxt_item_valid = 1'b0;
        nxt_cfg_valid  = 1'b0;
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (draining) begin
          // Wait out the pipeline once every result is in
          if (results_due == results_seen) begin
            if (settle > 0) settle--;
            else draining = 1'b0;
          end
        end else if (op_queue.size() > 0) begin
          cur_op = op_queue.pop_front();
          case (cur_op.code)
            OP_ITEM: begin
              nxt_item_valid   = 1'b1;
              item_ch.kind    <= cur_op.kind;
              item_ch.rx_byte <= cur_op.data;
              gap_cnt          = cur_op.gap;
            end
            OP_CFG: begin
              nxt_cfg_valid         = 1'b1;
              cfg_ch.timeout_ticks <= cur_op.value;
            end
            OP_DRAIN: begin
              draining = 1'b1;
              settle   = 3;
            end
            default: holdoff_tog <= ~holdoff_tog;
          endcase
        end else begin
          stim_done = 1'b1;
        end
        item_ch.valid <= nxt_item_valid;
        cfg_ch.valid  <= nxt_cfg_valid;
      end
    end
  end

  // Monitor: stall at random, check each result against the oldest expectation
  int         stall_cnt;
  int         holdoff_cnt;
  int         rx_run;
  bit         rx_calm;
  logic       holdoff_seen;
  rx_result_t got;
  rx_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      results_seen    <= 0;
      stall_cnt       = 0;
      holdoff_cnt     = 0;
      rx_run          = 0;
      rx_calm         = 1'b0;
      holdoff_seen    = 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = {result_ch.uart_valid, result_ch.uart_byte, result_ch.net_valid,
               result_ch.net_byte, result_ch.last, result_ch.binary_mode,
               result_ch.timed_out};
        results_seen <= results_seen + 1;
        if (exp_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("[%0t] unexpected result: uv=%0b ub=%02h nv=%0b nb=%02h last=%0b bin=%0b to=%0b",
                     $time, got.uart_valid, got.uart_byte, got.net_valid, got.net_byte,
                     got.last, got.binary_mode, got.timed_out);
        end else begin
          want = exp_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $display("[%0t] result %0d mismatch", $time, results_seen);
              $display("  expected uv=%0b ub=%02h nv=%0b nb=%02h last=%0b bin=%0b to=%0b",
                       want.uart_valid, want.uart_byte, want.net_valid, want.net_byte,
                       want.last, want.binary_mode, want.timed_out);
              $display("  actual   uv=%0b ub=%02h nv=%0b nb=%02h last=%0b bin=%0b to=%0b",
                       got.uart_valid, got.uart_byte, got.net_valid, got.net_byte,
                       got.last, got.binary_mode, got.timed_out);
            end
          end
        end
        // Draw the stall before the next result, with stall-free stretches
        if (rx_run == 0) begin
          rx_calm = ($urandom_range(0, 3) == 0);
          rx_run  = $urandom_range(20, 80);
        end
        rx_run--;
        stall_cnt = rx_calm ? 0 : $urandom_range(0, 16);
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end
      // Long hold-off on request from the driver
      if (holdoff_tog != holdoff_seen) begin
        holdoff_seen = holdoff_tog;
        holdoff_cnt  = HOLDOFF_CYCLES;
      end else if (holdoff_cnt > 0) begin
        holdoff_cnt--;
      end
      result_ch.ready <= (stall_cnt == 0) && (holdoff_cnt == 0);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  int idle_cycles;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.kind         = KIND_BYTE;
    item_ch.rx_byte      = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.timeout_ticks = '0;
    result_ch.ready      = 1'b0;
    errors               = 0;
    n_items              = 0;
    n_starts             = 0;
    n_resets             = 0;
    n_cfg                = 0;
    stim_done            = 1'b0;
    tx_calm              = 1'b0;

    // Directed: burst, plain bytes, escaped IAC, binary negotiation both ways,
    // ignored DONT, two-byte command, subnegotiation with inner IAC, tick, reset
    push_item(KIND_START, 8'hA5);
    push_bytes(8'h00, 8'hFE, 8'h00, 2);
    push_bytes(TN_IAC, TN_IAC, 8'h00, 2);
    push_bytes(TN_IAC, TN_WILL, OPT_BINARY, 3);
    push_bytes(TN_IAC, TN_DONT, OPT_BINARY, 3);
    push_bytes(TN_IAC, TN_DO, OPT_BINARY, 3);
    push_bytes(TN_IAC, TN_NOP, 8'h00, 2);
    push_bytes(TN_IAC, TN_SB, OPT_BINARY, 3);
    push_bytes(TN_IAC, 8'h07, 8'h00, 2);
    push_bytes(TN_IAC, TN_SE, 8'h00, 2);
    push_item(KIND_TICK, 8'h5A);
    push_item(KIND_RESET, 8'hFF);
    push_ctrl(OP_DRAIN, '0);

    // Zero timeout: flag is up at once until binary is negotiated
    push_ctrl(OP_CFG, '0);
    add_random_traffic(90);
    push_ctrl(OP_DRAIN, '0);

    // Short timeout, with a long receiver hold-off while items keep coming
    push_ctrl(OP_CFG, tick_t'($urandom_range(2, 12)));
    add_random_traffic(130);
    push_ctrl(OP_HOLDOFF, '0);
    tx_calm = 1'b1;
    add_random_traffic(160);
    tx_calm = 1'b0;
    add_random_traffic(190);
    push_ctrl(OP_DRAIN, '0);

    // Largest timeout
    push_ctrl(OP_CFG, TICK_MAX);
    add_random_traffic(260);
    push_ctrl(OP_DRAIN, '0);

    // Random small timeout
    push_ctrl(OP_CFG, tick_t'($urandom_range(0, 40)));
    add_random_traffic(350);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait until every expected result has been checked
    wait (stim_done);
    while ((results_due != results_seen) || (exp_results.size() != 0)) @(posedge clk);
    repeat (5) @(posedge clk);
    errors += exp_results.size();

    $display("Sent %0d items (%0d session starts, %0d connection resets), checked %0d results",
             n_items, n_starts, n_resets, results_seen);
    $display("Timeout limit written %0d times, including zero and the full 24-bit value", n_cfg);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
